### rtl/core/bresenham_line_points_unit_assert.svh
// Assertion macros used by the line rasterizer controller.
`ifndef BRESENHAM_LINE_POINTS_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_POINTS_UNIT_ASSERT_SVH

// Implication checked in the same cycle, clocked on clk and held off in reset.
`define BLP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// Implication checked in the next cycle.
`define BLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

### rtl/core/blp_pkg.sv
// Package with the types and constants of the line rasterizer.
package blp_pkg;

    localparam int COORD_W   = 6;
    localparam int GRID_SIZE = 64;

    typedef logic [COORD_W-1:0] coord_t;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } blp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } blp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } blp_status_t;

endpackage

### rtl/core/blp_ifs.sv
// Stream interfaces for line segments in and line points out.
interface blp_seg_if;
    logic                  valid;
    logic                  ready;
    logic [blp_pkg::COORD_W-1:0] start_x;
    logic [blp_pkg::COORD_W-1:0] start_y;
    logic [blp_pkg::COORD_W-1:0] end_x;
    logic [blp_pkg::COORD_W-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

interface blp_pt_if;
    logic                  valid;
    logic                  ready;
    logic [blp_pkg::COORD_W-1:0] point_x;
    logic [blp_pkg::COORD_W-1:0] point_y;
    logic                  last;

    modport source (output valid, output point_x, output point_y, output last,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last,
                    output ready);
endinterface

### rtl/core/blp_ctrl.sv
// Controller state machine of the line rasterizer.
`include "bresenham_line_points_unit_assert.svh"

module blp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  blp_pkg::blp_status_t status,
    output blp_pkg::blp_cmd_t    cmd
);

    blp_pkg::blp_state_t state_reg;
    blp_pkg::blp_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            blp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = blp_pkg::ST_RUN;
                end
            end
            blp_pkg::ST_RUN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last)
                    begin
                        state_next = blp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = blp_pkg::ST_IDLE;
            end
        endcase
    end

    // A new segment always produces at least one point.
    `BLP_ASSERT_NEXT(a_load_emits, in_valid && in_ready, out_valid)
    // The final point hands control back to the input side.
    `BLP_ASSERT_NEXT(a_last_frees, out_valid && out_ready && status.last, in_ready)
    // A point that is not the last one is followed by another.
    `BLP_ASSERT_NEXT(a_more_points, out_valid && out_ready && !status.last, out_valid)
    // Never load a segment while points are still going out.
    `BLP_ASSERT_SAME(a_no_overlap, cmd.load, !out_valid && !cmd.step)

endmodule

### rtl/core/blp_datapath.sv
// Datapath of the line rasterizer: setup, cursor and error term.
module blp_datapath #(
    parameter int GRID_SIZE = blp_pkg::GRID_SIZE
) (
    input  logic                         clk,
    input  blp_pkg::blp_cmd_t            cmd,
    input  logic [blp_pkg::COORD_W-1:0]  start_x,
    input  logic [blp_pkg::COORD_W-1:0]  start_y,
    input  logic [blp_pkg::COORD_W-1:0]  end_x,
    input  logic [blp_pkg::COORD_W-1:0]  end_y,
    output logic [blp_pkg::COORD_W-1:0]  point_x,
    output logic [blp_pkg::COORD_W-1:0]  point_y,
    output blp_pkg::blp_status_t         status
);

    localparam int W = blp_pkg::COORD_W;
    localparam logic [W-1:0] COORD_MAX = W'(GRID_SIZE - 1);

    logic [W-1:0] x0, y0, x1, y1;
    logic         x_up, y_up, steep;
    logic [W-1:0] span_x, span_y, major, minor;

    logic [W-1:0] cx_reg, cy_reg, err_reg, left_reg, major_reg, minor_reg;
    logic         steep_reg, x_up_reg, y_up_reg;
    logic [W-1:0] cx_next, cy_next, err_next;
    logic         wrap;
    logic [W:0]   err_wrap;

    // Saturate endpoints to the grid and derive spans and directions.
    always_comb
    begin
        x0     = (start_x > COORD_MAX) ? COORD_MAX : start_x;
        y0     = (start_y > COORD_MAX) ? COORD_MAX : start_y;
        x1     = (end_x > COORD_MAX) ? COORD_MAX : end_x;
        y1     = (end_y > COORD_MAX) ? COORD_MAX : end_y;
        x_up   = x1 >= x0;
        y_up   = y1 >= y0;
        span_x = x_up ? x1 - x0 : x0 - x1;
        span_y = y_up ? y1 - y0 : y0 - y1;
        steep  = span_y > span_x;
        major  = steep ? span_y : span_x;
        minor  = steep ? span_x : span_y;
    end

    // One step: major axis always moves, minor axis moves when the error wraps.
    always_comb
    begin
        wrap     = err_reg < minor_reg;
        err_wrap = {1'b0, err_reg} + {1'b0, major_reg} - {1'b0, minor_reg};
        err_next = wrap ? err_wrap[W-1:0] : err_reg - minor_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        if (steep_reg || wrap)
        begin
            cy_next = y_up_reg ? cy_reg + 1'b1 : cy_reg - 1'b1;
        end
        if (!steep_reg || wrap)
        begin
            cx_next = x_up_reg ? cx_reg + 1'b1 : cx_reg - 1'b1;
        end
    end

    // Cursor registers; they also serve as the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg    <= x0;
            cy_reg    <= y0;
            err_reg   <= major >> 1;
            left_reg  <= major;
            major_reg <= major;
            minor_reg <= minor;
            steep_reg <= steep;
            x_up_reg  <= x_up;
            y_up_reg  <= y_up;
        end
        else if (cmd.step)
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            err_reg  <= err_next;
            left_reg <= left_reg - 1'b1;
        end
    end

    assign point_x     = cx_reg;
    assign point_y     = cy_reg;
    assign status.last = (left_reg == '0);

endmodule

### rtl/core/bresenham_line_points_unit.sv
// Top level of the line rasterizer: segment in, grid points out.
//
//   Channel  Dir  Beat payload
//   seg      in   start_x, start_y, end_x, end_y (6 bits each)
//   pt       out  point_x, point_y (6 bits each), last
//
// A segment is taken while the unit is idle; its points follow one per
// cycle from the next cycle, as fast as pt.ready allows. With a single
// cursor register set, the next segment is taken only after the last point
// of the current one has gone out. Stalls on pt hold the current point.
// Reset (rst_n, asynchronous) returns the controller to idle; the datapath
// registers need no reset.
module bresenham_line_points_unit #(
    parameter int GRID_SIZE = blp_pkg::GRID_SIZE
) (
    input  logic  clk,
    input  logic  rst_n,
    blp_seg_if.sink  seg,
    blp_pt_if.source pt
);

    blp_pkg::blp_cmd_t    cmd;
    blp_pkg::blp_status_t status;

    blp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg.valid),
        .in_ready  (seg.ready),
        .out_valid (pt.valid),
        .out_ready (pt.ready),
        .status    (status),
        .cmd       (cmd)
    );

    blp_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk     (clk),
        .cmd     (cmd),
        .start_x (seg.start_x),
        .start_y (seg.start_y),
        .end_x   (seg.end_x),
        .end_y   (seg.end_y),
        .point_x (pt.point_x),
        .point_y (pt.point_y),
        .status  (status)
    );

    assign pt.last = status.last;

endmodule
